/* hdl/ber_tag_length_header_parser_assert.svh */
// ---------------------------------------------------------------------------
// BER header parser assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BER_TAG_LENGTH_HEADER_PARSER_ASSERT_SVH
`define BER_TAG_LENGTH_HEADER_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// The expression holds at every clock edge outside reset.
`define BTLH_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("BER header parser check failed");

// When the condition holds, the consequence holds in the following cycle.
`define BTLH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("BER header parser sequencing check failed");

`else

`define BTLH_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define BTLH_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* hdl/btlh_pkg.sv */
// ---------------------------------------------------------------------------
// btlh_pkg
// Types and constants shared by the BER tag and length header parser.
// ---------------------------------------------------------------------------
`default_nettype none

package btlh_pkg;

   // Sizing of the accumulators.
   localparam int TAG_NUMBER_BITS = 32;
   localparam int LENGTH_BYTES    = 8;
   localparam int LEN_ACC_BITS    = 8 * LENGTH_BYTES;
   localparam int LEN_SEEN_BITS   = $clog2(LENGTH_BYTES + 1);

   // Result status codes.
   localparam logic [3:0] ST_COMPLETE       = 4'd0;
   localparam logic [3:0] ST_EMPTY          = 4'd1;
   localparam logic [3:0] ST_NUM_INCOMPLETE = 4'd2;
   localparam logic [3:0] ST_NUM_OVERFLOW   = 4'd3;
   localparam logic [3:0] ST_LEN_MISSING    = 4'd4;
   localparam logic [3:0] ST_LEN_FF         = 4'd5;
   localparam logic [3:0] ST_INDEF_PRIM     = 4'd6;
   localparam logic [3:0] ST_LEN_INCOMPLETE = 4'd7;
   localparam logic [3:0] ST_LEN_OVERFLOW   = 4'd8;

   // Header shapes.
   localparam logic [1:0] SHAPE_PRIMITIVE  = 2'd0;
   localparam logic [1:0] SHAPE_DEFINITE   = 2'd1;
   localparam logic [1:0] SHAPE_INDEFINITE = 2'd2;

   // Octet codes.
   localparam logic [4:0] TAG_LONG_FORM  = 5'h1f;
   localparam logic [7:0] LEN_INDEFINITE = 8'h80;
   localparam logic [7:0] LEN_RESERVED   = 8'hff;

   typedef struct packed {
      logic [7:0] octet;
      logic       end_flag;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]  status;
      logic [1:0]  id_class;
      logic [1:0]  header_shape;
      logic [31:0] tag_value;
      logic [63:0] content_length;
   } rsp_payload_type;

endpackage

`default_nettype wire

/* hdl/ber_tag_length_header_parser.sv */
// ---------------------------------------------------------------------------
// ber_tag_length_header_parser
// Decodes BER identifier and length octets, one octet per beat.
// ---------------------------------------------------------------------------
// Usage:
// The req channel carries one octet per beat, or an end-of-stream beat with
// end_flag set. Each beat is decoded in the cycle it is accepted, so the
// parser takes one beat per clock cycle with no bubbles while req_stall is
// low. A header that completes or fails yields one rsp beat (status, class,
// shape, tag number, content length), registered in the output register,
// or the skid register while the output stalls; other beats produce nothing.
// After every result the next octet is parsed as a new identifier octet.
// The rsp side has an output register backed by one skid register. When the
// receiver stalls, up to two results are held; req_stall rises only while
// the skid register is occupied, so input keeps flowing one beat per cycle
// as long as the receiver takes at least one result per cycle on average.
// A synchronous reset returns the parser to waiting for an identifier octet
// and empties both result registers. There is no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

`include "ber_tag_length_header_parser_assert.svh"

module ber_tag_length_header_parser
   import btlh_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_stall,
   input  wire req_payload_type req_payload,
   output      logic            rsp_valid,
   input  wire logic            rsp_stall,
   output      rsp_payload_type rsp_payload
);

   typedef enum logic [3:0] {
      PH_IDENT    = 4'b0001,
      PH_TAGNUM   = 4'b0010,
      PH_LENOCT   = 4'b0100,
      PH_LENBYTES = 4'b1000
   } phase_type;

   phase_type                  phase_ff, phase_in;
   logic [1:0]                 class_ff, class_in;
   logic                       cons_ff, cons_in;
   logic [TAG_NUMBER_BITS-1:0] number_ff, number_in;
   logic [LEN_ACC_BITS-1:0]    len_acc_ff, len_acc_in;
   logic [6:0]                 len_left_ff, len_left_in;
   logic [LEN_SEEN_BITS-1:0]   len_seen_ff, len_seen_in;

   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type skid_ff, skid_in;

   logic            req_fire;
   logic            rsp_fire;
   logic            emit;
   rsp_payload_type result;
   logic [7:0]      octet;
   logic [1:0]      def_shape;
   logic [6:0]      left_dec;
   logic [LEN_ACC_BITS-1:0] len_shifted;
   logic            stalled_emit;
   logic            ident_clean;

   assign req_stall = skid_valid_ff;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = out_valid_ff && !rsp_stall;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   assign octet       = req_payload.octet;
   assign def_shape   = cons_ff ? SHAPE_DEFINITE : SHAPE_PRIMITIVE;
   assign left_dec    = len_left_ff - 7'd1;
   assign len_shifted = (len_acc_ff << 8) | LEN_ACC_BITS'(octet);

   // Decode one beat against the current parse state.
   always_comb begin
      phase_in    = phase_ff;
      class_in    = class_ff;
      cons_in     = cons_ff;
      number_in   = number_ff;
      len_acc_in  = len_acc_ff;
      len_left_in = len_left_ff;
      len_seen_in = len_seen_ff;
      emit        = 1'b0;

      result.status         = ST_COMPLETE;
      result.id_class       = class_ff;
      result.header_shape   = SHAPE_PRIMITIVE;
      result.tag_value      = 32'(number_ff);
      result.content_length = 64'd0;

      case (phase_ff)
         PH_TAGNUM: begin
            if (req_payload.end_flag) begin
               emit          = 1'b1;
               result.status = ST_NUM_INCOMPLETE;
            end else if (number_ff[TAG_NUMBER_BITS-1 -: 7] != 7'd0) begin
               // Another base-128 group would push set bits off the top.
               emit          = 1'b1;
               result.status = ST_NUM_OVERFLOW;
            end else begin
               number_in = {number_ff[TAG_NUMBER_BITS-8:0], octet[6:0]};
               if (!octet[7]) begin
                  phase_in = PH_LENOCT;
               end
            end
         end
         PH_LENOCT: begin
            if (req_payload.end_flag) begin
               emit          = 1'b1;
               result.status = ST_LEN_MISSING;
            end else if (octet == LEN_RESERVED) begin
               emit          = 1'b1;
               result.status = ST_LEN_FF;
            end else if (octet == LEN_INDEFINITE) begin
               emit = 1'b1;
               if (!cons_ff) begin
                  result.status = ST_INDEF_PRIM;
               end else begin
                  result.status       = ST_COMPLETE;
                  result.header_shape = SHAPE_INDEFINITE;
               end
            end else if (octet[7]) begin
               len_left_in = octet[6:0];
               len_seen_in = '0;
               len_acc_in  = '0;
               phase_in    = PH_LENBYTES;
            end else begin
               emit                  = 1'b1;
               result.status         = ST_COMPLETE;
               result.header_shape   = def_shape;
               result.content_length = 64'(octet);
            end
         end
         PH_LENBYTES: begin
            if (req_payload.end_flag) begin
               emit                = 1'b1;
               result.status       = ST_LEN_INCOMPLETE;
               result.header_shape = def_shape;
            end else if (32'(len_seen_ff) >= LENGTH_BYTES) begin
               emit                = 1'b1;
               result.status       = ST_LEN_OVERFLOW;
               result.header_shape = def_shape;
            end else begin
               len_acc_in  = len_shifted;
               len_seen_in = len_seen_ff + LEN_SEEN_BITS'(1);
               len_left_in = left_dec;
               if (left_dec == 7'd0) begin
                  emit                  = 1'b1;
                  result.status         = ST_COMPLETE;
                  result.header_shape   = def_shape;
                  result.content_length = 64'(len_shifted);
               end
            end
         end
         default: begin
            if (req_payload.end_flag) begin
               emit          = 1'b1;
               result.status = ST_EMPTY;
            end else begin
               class_in = octet[7:6];
               cons_in  = octet[5];
               if (octet[4:0] != TAG_LONG_FORM) begin
                  number_in = TAG_NUMBER_BITS'(octet[4:0]);
                  phase_in  = PH_LENOCT;
               end else begin
                  number_in = '0;
                  phase_in  = PH_TAGNUM;
               end
            end
         end
      endcase

      // Every result sends the parser back to the identifier octet.
      if (emit) begin
         phase_in    = PH_IDENT;
         class_in    = 2'd0;
         cons_in     = 1'b0;
         number_in   = '0;
         len_acc_in  = '0;
         len_left_in = 7'd0;
         len_seen_in = '0;
      end
   end

   // Output register with one skid entry behind it.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || rsp_fire) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = req_fire && emit;
            out_in       = result;
         end
      end else if (req_fire && emit) begin
         skid_valid_in = 1'b1;
         skid_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDENT;
         class_ff      <= 2'd0;
         cons_ff       <= 1'b0;
         number_ff     <= '0;
         len_acc_ff    <= '0;
         len_left_ff   <= 7'd0;
         len_seen_ff   <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            phase_ff    <= phase_in;
            class_ff    <= class_in;
            cons_ff     <= cons_in;
            number_ff   <= number_in;
            len_acc_ff  <= len_acc_in;
            len_left_ff <= len_left_in;
            len_seen_ff <= len_seen_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign stalled_emit = req_fire && emit && out_valid_ff && rsp_stall;
   assign ident_clean  = (number_ff == '0) && (class_ff == 2'd0);

   `BTLH_ASSERT_ALWAYS(a_skid_behind_out, clock, reset, !skid_valid_ff || out_valid_ff)
   `BTLH_ASSERT_NEXT(a_stalled_result_to_skid, clock, reset, stalled_emit, skid_valid_ff)
   `BTLH_ASSERT_ALWAYS(a_len_seen_bound, clock, reset, 32'(len_seen_ff) <= LENGTH_BYTES)
   `BTLH_ASSERT_ALWAYS(a_ident_clean, clock, reset, phase_ff != PH_IDENT || ident_clean)

endmodule

`default_nettype wire

/* verif/btlh_result_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// BER header result checker
// Watches both channels of the BER tag and length header parser. Every
// accepted req beat runs through a local header decoder; every header it
// closes is queued, and each accepted rsp beat is checked against the
// oldest queued header, field by field.
// ---------------------------------------------------------------------------

module btlh_result_checker
   import btlh_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_stall,
   input  wire req_payload_type req_payload,
   input  wire logic            rsp_valid,
   input  wire logic            rsp_stall,
   input  wire rsp_payload_type rsp_payload,
   output int                   mismatch_count,
   output int                   headers_outstanding
);

   typedef enum logic [1:0] {
      AWAIT_IDENT,
      IN_TAG_NUMBER,
      AWAIT_LENGTH,
      IN_LENGTH_BYTES
   } parse_phase_type;

   parse_phase_type            phase;
   logic [1:0]                 class_held;
   logic                       constructed_held;
   logic [TAG_NUMBER_BITS-1:0] tag_acc;
   logic [LEN_ACC_BITS-1:0]    len_acc;
   logic [6:0]                 len_left;
   logic [LEN_SEEN_BITS-1:0]   len_seen;

   rsp_payload_type expected_headers [$];
   int              fails = 0;

   task automatic start_over();
      phase            = AWAIT_IDENT;
      class_held       = '0;
      constructed_held = 1'b0;
      tag_acc          = '0;
      len_acc          = '0;
      len_left         = '0;
      len_seen         = '0;
   endtask

   task automatic close_header(logic [3:0] status, logic [1:0] shape, logic [63:0] length);
      rsp_payload_type hdr;
      hdr.status         = status;
      hdr.id_class       = class_held;
      hdr.header_shape   = shape;
      hdr.tag_value      = 32'(tag_acc);
      hdr.content_length = length;
      expected_headers.push_back(hdr);
      start_over();
   endtask

   task automatic decode_beat(req_payload_type beat);
      logic [7:0] o;
      logic [1:0] def_shape;
      o         = beat.octet;
      def_shape = constructed_held ? SHAPE_DEFINITE : SHAPE_PRIMITIVE;
      case (phase)
         IN_TAG_NUMBER: begin
            if (beat.end_flag) begin
               close_header(ST_NUM_INCOMPLETE, SHAPE_PRIMITIVE, '0);
            end else if ((tag_acc >> (TAG_NUMBER_BITS - 7)) != 0) begin
               // The next shift would push set bits out of the accumulator.
               close_header(ST_NUM_OVERFLOW, SHAPE_PRIMITIVE, '0);
            end else begin
               tag_acc = {tag_acc[TAG_NUMBER_BITS-8:0], o[6:0]};
               if (!o[7]) phase = AWAIT_LENGTH;
            end
         end
         AWAIT_LENGTH: begin
            if (beat.end_flag) begin
               close_header(ST_LEN_MISSING, SHAPE_PRIMITIVE, '0);
            end else if (o == LEN_RESERVED) begin
               close_header(ST_LEN_FF, SHAPE_PRIMITIVE, '0);
            end else if (o == LEN_INDEFINITE) begin
               if (!constructed_held) close_header(ST_INDEF_PRIM, SHAPE_PRIMITIVE, '0);
               else close_header(ST_COMPLETE, SHAPE_INDEFINITE, '0);
            end else if (o[7]) begin
               len_left = o[6:0];
               len_seen = '0;
               len_acc  = '0;
               phase    = IN_LENGTH_BYTES;
            end else begin
               close_header(ST_COMPLETE, def_shape, 64'(o));
            end
         end
         IN_LENGTH_BYTES: begin
            if (beat.end_flag) begin
               close_header(ST_LEN_INCOMPLETE, def_shape, '0);
            end else if (len_seen >= LENGTH_BYTES) begin
               close_header(ST_LEN_OVERFLOW, def_shape, '0);
            end else begin
               len_acc  = {len_acc[LEN_ACC_BITS-9:0], o};
               len_seen = len_seen + LEN_SEEN_BITS'(1);
               len_left = len_left - 7'd1;
               if (len_left == 0) close_header(ST_COMPLETE, def_shape, 64'(len_acc));
            end
         end
         default: begin
            if (beat.end_flag) begin
               close_header(ST_EMPTY, SHAPE_PRIMITIVE, '0);
            end else begin
               start_over();
               class_held       = o[7:6];
               constructed_held = o[5];
               if (o[4:0] != TAG_LONG_FORM) begin
                  tag_acc = TAG_NUMBER_BITS'(o[4:0]);
                  phase   = AWAIT_LENGTH;
               end else begin
                  phase = IN_TAG_NUMBER;
               end
            end
         end
      endcase
   endtask

   task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         fails++;
         $display("%0t: rsp %s mismatch, expected %0h, got %0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         start_over();
         expected_headers.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_headers.size() == 0) begin
               fails++;
               $display("%0t: rsp beat with no header pending, status %0h", $time,
                        rsp_payload.status);
            end else begin
               want = expected_headers.pop_front();
               compare_field("status", 64'(want.status), 64'(rsp_payload.status));
               compare_field("id_class", 64'(want.id_class), 64'(rsp_payload.id_class));
               compare_field("header_shape", 64'(want.header_shape),
                             64'(rsp_payload.header_shape));
               compare_field("tag_value", 64'(want.tag_value), 64'(rsp_payload.tag_value));
               compare_field("content_length", want.content_length,
                             rsp_payload.content_length);
            end
         end
         if (req_valid && !req_stall) decode_beat(req_payload);
      end
      mismatch_count      <= fails;
      headers_outstanding <= expected_headers.size();
   end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// BER tag and length header parser testbench
// Feeds directed headers covering each error path but the length overflow,
// then random streams of mostly well-formed headers with truncations and noise,
// under three idle and stall patterns and one long receiver hold-off. The checker
// module does all prediction and comparison; this top only drives and decides.
// ---------------------------------------------------------------------------

module testbench;
   import btlh_pkg::*;

   localparam int          TIMEOUT_NS      = 400_000;
   localparam int          DRAIN_CYCLES    = 8;
   localparam int          HOLD_OFF_CYCLES = 80;
   localparam int          RANDOM_BEATS    = 1250;
   localparam logic [8:0]  END_BEAT        = 9'h100;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;

   int   mismatch_count;
   int   headers_outstanding;
   int   beats_sent         = 0;
   int   sender_idle_pct    = 16;
   int   receiver_stall_pct = 65;
   logic hold_off_go        = 1'b0;

   // Directed stream: {end_flag, octet} per beat.
   logic [8:0] directed_beats [$] = '{
      END_BEAT,
      9'h000, 9'h000,
      9'h0fe, {1'b0, LEN_INDEFINITE},
      9'h002, {1'b0, LEN_INDEFINITE},
      9'h004, {1'b0, LEN_RESERVED},
      9'h041, END_BEAT,
      9'h09f, 9'h080, 9'h005, 9'h07f,
      9'h03f, 9'h081, END_BEAT,
      {4'b0000, TAG_LONG_FORM}, 9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff, 9'h080,
      9'h030, 9'h082, 9'h0ab, END_BEAT
   };

   always #2 clock = ~clock;

   ber_tag_length_header_parser uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   btlh_result_checker result_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_payload         (req_payload),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_payload         (rsp_payload),
      .mismatch_count      (mismatch_count),
      .headers_outstanding (headers_outstanding)
   );

   function automatic req_payload_type make_beat(logic [7:0] octet, logic end_flag);
      req_payload_type beat;
      beat.octet    = octet;
      beat.end_flag = end_flag;
      return beat;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_beat(req_payload_type beat);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic send_random_header();
      req_payload_type beats [$];
      logic [1:0]      cls;
      logic            cons;
      logic [7:0]      grp;
      int              groups;
      int              count;
      int              pick;
      int              cut;
      int              g;
      cls  = 2'($urandom_range(3));
      cons = 1'($urandom_range(1));
      if ($urandom_range(11) == 0) begin
         repeat ($urandom_range(1, 4))
            beats.push_back(make_beat(8'($urandom_range(255)), 1'($urandom_range(1))));
      end else begin
         if ($urandom_range(9) < 6) begin
            beats.push_back(make_beat({cls, cons, 5'($urandom_range(30))}, 1'b0));
         end else begin
            beats.push_back(make_beat({cls, cons, TAG_LONG_FORM}, 1'b0));
            // Six or seven groups overflow unless the leading groups are zero or small;
            // five overflow only when the first group is large.
            groups = ($urandom_range(7) == 0) ? $urandom_range(6, 7) : $urandom_range(1, 5);
            for (g = 0; g < groups; g++) begin
               grp    = 8'($urandom_range(127));
               grp[7] = (g != groups - 1);
               beats.push_back(make_beat(grp, 1'b0));
            end
         end
         pick = $urandom_range(19);
         if (pick < 8) begin
            beats.push_back(make_beat(8'($urandom_range(127)), 1'b0));
         end else if (pick < 10) begin
            beats.push_back(make_beat(LEN_INDEFINITE, 1'b0));
         end else if (pick == 10) begin
            beats.push_back(make_beat(LEN_RESERVED, 1'b0));
         end else begin
            count = (pick == 19) ? $urandom_range(LENGTH_BYTES + 1, 126)
                                 : $urandom_range(1, LENGTH_BYTES);
            beats.push_back(make_beat({1'b1, 7'(count)}, 1'b0));
            repeat ((count > LENGTH_BYTES) ? LENGTH_BYTES + 1 : count)
               beats.push_back(make_beat(8'($urandom_range(255)), 1'b0));
         end
      end
      if ($urandom_range(9) == 0) begin
         cut = $urandom_range(beats.size() - 1);
         while (beats.size() > cut) void'(beats.pop_back());
         beats.push_back(make_beat(8'($urandom_range(255)), 1'b1));
      end
      foreach (beats[i]) send_beat(beats[i]);
   endtask

   // Receiver: random stalls, plus one long hold-off once requested.
   initial begin
      int held;
      held      = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_go && held < HOLD_OFF_CYCLES) begin
            rsp_stall <= 1'b1;
            held++;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   initial begin
      int phase_idx;
      int target;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_beats[i])
         send_beat(make_beat(directed_beats[i][7:0], directed_beats[i][8]));

      for (phase_idx = 0; phase_idx < 3; phase_idx++) begin
         case (phase_idx)
            0: begin
               sender_idle_pct    = 16;
               receiver_stall_pct <= 65;
            end
            1: begin
               sender_idle_pct    = 65;
               receiver_stall_pct <= 16;
            end
            default: begin
               sender_idle_pct    = 0;
               receiver_stall_pct <= 0;
               hold_off_go        <= 1'b1;
            end
         endcase
         target = directed_beats.size() + (phase_idx + 1) * RANDOM_BEATS / 3;
         while (beats_sent < target) send_random_header();
      end

      req_valid <= 1'b0;
      while (headers_outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && headers_outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #TIMEOUT_NS;
      $display("TB_ERROR");
      $finish;
   end

endmodule

/* files.f */
+incdir+hdl
hdl/btlh_pkg.sv
hdl/ber_tag_length_header_parser.sv
verif/btlh_result_checker.sv
verif/testbench.sv
